FILE: src/chbr_pkg.sv
// ----------------------------------------------------------------------------
// chbr_pkg: shared types, constants and rotate helpers
// Types for the chained byte rotate cipher and its 8-bit rotate functions.
// ----------------------------------------------------------------------------
`default_nettype none

package chbr_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [63:0] key_type;

   typedef enum logic {
      OP_DECRYPT = 1'b0,
      OP_ENCRYPT = 1'b1
   } opcode_type;

   localparam int       ROUND_COUNT = 7;
   localparam byte_type CHAIN_RESET = 8'hff;
   localparam key_type  KEY_RESET   = 64'd0;

   typedef struct packed {
      byte_type   data_byte;
      opcode_type opcode;
      logic       first;
      byte_type   seed;
   } req_beat_type;

   typedef struct packed {
      byte_type   data_byte;
      opcode_type opcode;
      byte_type   chain_byte;
   } core_req_type;

   typedef struct packed {
      byte_type result_byte;
      byte_type chain_next;
   } core_rsp_type;

   function automatic byte_type rotl8(byte_type x, logic [2:0] r);
      logic [15:0] dbl;
      dbl = {x, x} << r;
      return dbl[15:8];
   endfunction

   function automatic byte_type rotr8(byte_type x, logic [2:0] r);
      logic [15:0] dbl;
      dbl = {x, x} >> r;
      return dbl[7:0];
   endfunction

endpackage

`default_nettype wire

FILE: src/chbr_req_if.sv
// ----------------------------------------------------------------------------
// chbr_req_if: request channel
// Valid/ready channel carrying one data byte with its opcode, first flag and seed.
// ----------------------------------------------------------------------------
`default_nettype none

interface chbr_req_if;
   logic                 valid;
   logic                 ready;
   chbr_pkg::byte_type   data_byte;
   chbr_pkg::opcode_type opcode;
   logic                 first;
   chbr_pkg::byte_type   seed;

   modport source (output valid, output data_byte, output opcode, output first,
                   output seed, input ready);
   modport sink   (input valid, input data_byte, input opcode, input first,
                   input seed, output ready);
endinterface

`default_nettype wire

FILE: src/chbr_rsp_if.sv
// ----------------------------------------------------------------------------
// chbr_rsp_if: response channel
// Valid/ready channel carrying one result byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface chbr_rsp_if;
   logic               valid;
   logic               ready;
   chbr_pkg::byte_type result_byte;

   modport source (output valid, output result_byte, input ready);
   modport sink   (input valid, input result_byte, output ready);
endinterface

`default_nettype wire

FILE: src/chbr_csr_if.sv
// ----------------------------------------------------------------------------
// chbr_csr_if: key write channel
// Valid/ready channel carrying the 64-bit cipher key write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface chbr_csr_if;
   logic              valid;
   logic              ready;
   chbr_pkg::key_type cipher_key;

   modport source (output valid, output cipher_key, input ready);
   modport sink   (input valid, input cipher_key, output ready);
endinterface

`default_nettype wire

FILE: src/chbr_core.sv
// ----------------------------------------------------------------------------
// chbr_core: cipher datapath
// Whitening plus seven add-and-rotate rounds, forward or inverse, in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module chbr_core (
   input  chbr_pkg::key_type      cipher_key,
   input  chbr_pkg::core_req_type core_req,
   output chbr_pkg::core_rsp_type core_rsp
);
   import chbr_pkg::*;

   byte_type key0;
   byte_type enc_x;
   byte_type dec_x;

   assign key0 = cipher_key[7:0];

   always_comb begin
      byte_type k;
      enc_x = (core_req.data_byte ^ core_req.chain_byte) + key0;
      for (int i = 1; i <= ROUND_COUNT; i++) begin
         k     = cipher_key[8*i +: 8];
         enc_x = rotl8(enc_x, k[7:5]) + {3'b000, k[4:0]};
      end
   end

   always_comb begin
      byte_type k;
      dec_x = core_req.data_byte;
      for (int i = ROUND_COUNT; i >= 1; i--) begin
         k     = cipher_key[8*i +: 8];
         dec_x = rotr8(dec_x - {3'b000, k[4:0]}, k[7:5]);
      end
      dec_x = (dec_x - key0) ^ core_req.chain_byte;
   end

   always_comb begin
      case (core_req.opcode)
         OP_ENCRYPT: begin
            core_rsp.result_byte = enc_x;
            core_rsp.chain_next  = enc_x;
         end
         OP_DECRYPT: begin
            core_rsp.result_byte = dec_x;
            core_rsp.chain_next  = core_req.data_byte;
         end
         default: begin
            core_rsp.result_byte = dec_x;
            core_rsp.chain_next  = core_req.data_byte;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: src/chained_byte_rotate_cipher.sv
// ----------------------------------------------------------------------------
// chained_byte_rotate_cipher: byte cipher with ciphertext chaining
// Input register, one-pass cipher datapath, result register; chain byte
// updated as each beat moves into the result register.
//
//   channel    dir   beat contents
//   req_chan   in    data_byte, opcode, first, seed
//   rsp_chan   out   result_byte
//   csr_chan   in    cipher_key (64 bits)
//
// One beat per cycle sustained while rsp_chan.ready is high.
// The chain byte is read and rewritten in the same cycle by the datapath stage.
// Synchronous reset clears both stage valids, the chain byte (0xff) and the key.
// A stalled response holds the result register; the input register holds
// behind it, and req_chan.ready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_byte_rotate_cipher (
   input  wire logic   clock,
   input  wire logic   reset,
   chbr_req_if.sink    req_chan,
   chbr_rsp_if.source  rsp_chan,
   chbr_csr_if.sink    csr_chan
);
   import chbr_pkg::*;

   key_type      key_ff;
   byte_type     chain_ff;
   byte_type     chain_in;
   logic         in_valid_ff;
   req_beat_type in_beat_ff;
   logic         out_valid_ff;
   byte_type     out_byte_ff;
   logic         advance;
   core_req_type core_req;
   core_rsp_type core_rsp;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= KEY_RESET;
      end else if (csr_chan.valid) begin
         key_ff <= csr_chan.cipher_key;
      end
   end

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_beat_ff.data_byte <= req_chan.data_byte;
         in_beat_ff.opcode    <= req_chan.opcode;
         in_beat_ff.first     <= req_chan.first;
         in_beat_ff.seed      <= req_chan.seed;
      end
   end

   assign chain_in = in_beat_ff.first ? in_beat_ff.seed : chain_ff;

   assign core_req.data_byte  = in_beat_ff.data_byte;
   assign core_req.opcode     = in_beat_ff.opcode;
   assign core_req.chain_byte = chain_in;

   chbr_core u_core (
      .cipher_key (key_ff),
      .core_req   (core_req),
      .core_rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= CHAIN_RESET;
      end else if (advance) begin
         chain_ff <= core_rsp.chain_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff <= core_rsp.result_byte;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.result_byte = out_byte_ff;

   a_enc_chain: assert property (@(posedge clock) disable iff (reset)
      (advance && in_beat_ff.opcode == OP_ENCRYPT) |=> chain_ff == out_byte_ff)
      else $error("chain byte differs from the cipher byte just produced");

   a_dec_chain: assert property (@(posedge clock) disable iff (reset)
      (advance && in_beat_ff.opcode == OP_DECRYPT)
      |=> chain_ff == $past(in_beat_ff.data_byte))
      else $error("chain byte differs from the cipher byte just consumed");

   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_valid_ff) |-> advance)
      else $error("input beat held while the result register is empty");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(in_beat_ff))
      else $error("stalled input beat was dropped or changed");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: chained_byte_rotate_cipher testbench
// Drives request beats and key writes, predicts every result byte from a
// local copy of the key and chain byte, and checks each response beat in
// order. Runs a short edge-case pass, then round-trip messages (encrypt then
// decrypt of the same ciphertext) mixed with noise and broken messages, under
// four sender/receiver idling phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import chbr_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int PRINT_LIMIT = 40;

   logic clock;
   logic reset;

   chbr_req_if req_chan ();
   chbr_rsp_if rsp_chan ();
   chbr_csr_if csr_chan ();

   chained_byte_rotate_cipher u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   key_type  key_shadow;
   byte_type chain_shadow;
   byte_type want_queue[$];
   int       req_gap_pct;
   int       rsp_stall_pct;
   int       error_count;
   int       idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic byte_type rot_left(byte_type x, logic [2:0] r);
      return (x << r) | (x >> (4'd8 - r));
   endfunction

   function automatic byte_type rot_right(byte_type x, logic [2:0] r);
      return (x >> r) | (x << (4'd8 - r));
   endfunction

   function automatic byte_type cipher_byte(byte_type data, opcode_type op,
                                            byte_type chain, key_type key);
      byte_type x;
      byte_type k;
      int       i;
      if (op == OP_ENCRYPT) begin
         x = (data ^ chain) + key[7:0];
         for (i = 1; i < 8; i++) begin
            k = key[8*i +: 8];
            x = rot_left(x, k[7:5]);
            x = x + {3'b000, k[4:0]};
         end
      end else begin
         x = data;
         for (i = 7; i > 0; i--) begin
            k = key[8*i +: 8];
            x = x - {3'b000, k[4:0]};
            x = rot_right(x, k[7:5]);
         end
         x = (x - key[7:0]) ^ chain;
      end
      return x;
   endfunction

   task automatic report_mismatch(string what, byte_type got, byte_type want);
      if (error_count < PRINT_LIMIT)
         $display("[%0t] mismatch: %s: got %02h want %02h", $time, what, got, want);
      error_count++;
   endtask

   task automatic send_byte(byte_type data, opcode_type op, logic first, byte_type seed);
      byte_type res;
      while ($urandom_range(99) < req_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= data;
      req_chan.opcode    <= op;
      req_chan.first     <= first;
      req_chan.seed      <= seed;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (first) chain_shadow = seed;
      res = cipher_byte(data, op, chain_shadow, key_shadow);
      chain_shadow = (op == OP_ENCRYPT) ? res : data;
      want_queue.push_back(res);
   endtask

   // drop valid, wait for every result, then let the pipeline empty
   task automatic settle_traffic();
      req_chan.valid <= 1'b0;
      while (want_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_key(key_type key);
      settle_traffic();
      csr_chan.valid      <= 1'b1;
      csr_chan.cipher_key <= key;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      key_shadow = key;
   endtask

   task automatic test_chain_after_reset();
      send_byte(8'h00, OP_ENCRYPT, 1'b0, 8'h5a);
      send_byte(8'hff, OP_DECRYPT, 1'b0, 8'ha5);
      send_byte(8'h3c, OP_ENCRYPT, 1'b0, 8'hff);
   endtask

   task automatic test_key_extremes();
      load_key(64'hffff_ffff_ffff_ffff);
      send_byte(8'h00, OP_ENCRYPT, 1'b1, 8'h00);
      send_byte(8'hff, OP_ENCRYPT, 1'b0, 8'hff);
      send_byte(8'h00, OP_DECRYPT, 1'b1, 8'hff);
      send_byte(8'hff, OP_DECRYPT, 1'b0, 8'h00);
      send_byte(8'h81, OP_ENCRYPT, 1'b0, 8'h7e);
      // rotate fields all zero: adds only
      load_key(64'h1f1f_1f1f_1f1f_1fa5);
      send_byte(8'h7f, OP_ENCRYPT, 1'b1, 8'h80);
      send_byte(8'h80, OP_DECRYPT, 1'b0, 8'h00);
      send_byte(8'h01, OP_ENCRYPT, 1'b0, 8'hfe);
      load_key(64'h0123_4567_89ab_cdef);
      send_byte(8'h55, OP_ENCRYPT, 1'b1, 8'h01);
      send_byte(8'haa, OP_ENCRYPT, 1'b0, 8'h10);
      send_byte(8'h55, OP_DECRYPT, 1'b1, 8'h01);
      send_byte(8'haa, OP_DECRYPT, 1'b0, 8'h10);
      load_key(64'h0000_0000_0000_0000);
      send_byte(8'hc3, OP_DECRYPT, 1'b0, 8'h99);
      send_byte(8'h3c, OP_ENCRYPT, 1'b1, 8'hff);
   endtask

   task automatic test_random_traffic(int gap_pct, int stall_pct, int budget);
      byte_type msg[$];
      byte_type seed;
      byte_type plain;
      byte_type data;
      byte_type chain;
      int       sent;
      int       len;
      int       kind;
      int       bad_idx;
      int       next_key;
      int       i;
      key_type  key;
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      sent     = 0;
      next_key = 0;
      while (sent < budget) begin
         if (sent >= next_key) begin
            key = {$urandom, $urandom};
            case ($urandom_range(3))
               0: key = key & 64'h1f1f_1f1f_1f1f_1fff;
               1: key = key | 64'he0e0_e0e0_e0e0_e000;
               default: ;
            endcase
            load_key(key);
            next_key = sent + 100;
         end
         kind = $urandom_range(99);
         if (kind < 20) begin
            send_byte(byte_type'($urandom), opcode_type'($urandom_range(1)),
                      1'($urandom_range(1)), byte_type'($urandom));
            sent++;
         end else begin
            len  = $urandom_range(1, 12);
            seed = byte_type'($urandom);
            chain = seed;
            msg.delete();
            for (i = 0; i < len; i++) begin
               plain = byte_type'($urandom);
               msg.push_back(cipher_byte(plain, OP_ENCRYPT, chain, key_shadow));
               chain = msg[i];
               send_byte(plain, OP_ENCRYPT, i == 0, (i == 0) ? seed : byte_type'($urandom));
            end
            bad_idx = (kind >= 85) ? $urandom_range(len - 1) : -1;
            for (i = 0; i < len; i++) begin
               data = msg[i];
               if (i == bad_idx && kind < 92) data = data ^ byte_type'($urandom_range(1, 255));
               send_byte(data, OP_DECRYPT, (i == 0) && !(i == bad_idx && kind >= 92), seed);
            end
            sent += 2 * len;
         end
      end
      settle_traffic();
   endtask

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : check_rsp
      byte_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (want_queue.size() == 0) begin
            report_mismatch("result beat with nothing expected", rsp_chan.result_byte, 8'h00);
         end else begin
            want = want_queue.pop_front();
            if (rsp_chan.result_byte !== want)
               report_mismatch("result_byte", rsp_chan.result_byte, want);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("[%0t] timeout: no beat moved for %0d cycles", $time, IDLE_LIMIT);
         $display("** chained_byte_rotate_cipher: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.data_byte  = 8'h00;
      req_chan.opcode     = OP_DECRYPT;
      req_chan.first      = 1'b0;
      req_chan.seed       = 8'h00;
      rsp_chan.ready      = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.cipher_key = 64'd0;
      key_shadow          = KEY_RESET;
      chain_shadow        = CHAIN_RESET;
      req_gap_pct         = 0;
      rsp_stall_pct       = 0;
      error_count         = 0;
      idle_cycles         = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_chain_after_reset();
      test_key_extremes();
      test_random_traffic(0, 0, 300);
      test_random_traffic(45, 0, 300);
      test_random_traffic(0, 45, 300);
      test_random_traffic(21, 21, 300);
      settle_traffic();
      if (error_count == 0) begin
         $display("** chained_byte_rotate_cipher: PASSED **");
      end else begin
         $display("** chained_byte_rotate_cipher: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
src/chbr_pkg.sv
src/chbr_req_if.sv
src/chbr_rsp_if.sv
src/chbr_csr_if.sv
src/chbr_core.sv
src/chained_byte_rotate_cipher.sv
verif/tb.sv
